FILE: design/hsv2rgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and helpers for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// Request payloads
	typedef struct packed {
		logic [8:0] hue;
		logic [6:0] saturation;
		logic [6:0] brightness;
	} hsv_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_req_t;

	// Sextant codes, named after the hue span they cover
	localparam logic [2:0] SEXT_RY = 3'd0;  // red to yellow
	localparam logic [2:0] SEXT_YG = 3'd1;  // yellow to green
	localparam logic [2:0] SEXT_GC = 3'd2;  // green to cyan
	localparam logic [2:0] SEXT_CB = 3'd3;  // cyan to blue
	localparam logic [2:0] SEXT_BM = 3'd4;  // blue to magenta
	localparam logic [2:0] SEXT_MR = 3'd5;  // magenta to red

	localparam logic [8:0]  HUE_FULL    = 9'd360;
	localparam logic [8:0]  SEXT_DEG    = 9'd60;
	localparam logic [6:0]  PCT_MAX     = 7'd100;
	// x/100 as (x*RECIP_PCT) >> RECIP_SHIFT, exact for x below 43690
	localparam logic [14:0] RECIP_PCT   = 15'd20972;
	localparam int          RECIP_SHIFT = 21;

	// Output of the scaling half
	typedef struct packed {
		logic       sat_zero;
		logic [2:0] sextant;
		logic [7:0] sat_b;
		logic [7:0] val_b;
		logic [7:0] frac;
	} split_t;

	// Output of the blending half
	typedef struct packed {
		logic       sat_zero;
		logic [2:0] sextant;
		logic [7:0] val_b;
		logic [7:0] p;
		logic [7:0] q;
		logic [7:0] t;
	} mix_t;

	// Truncating x/255 for x up to 255*255: (x + (x>>8) + 1) >> 8
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] acc;
		acc = {1'b0, x} + 17'(x[15:8]) + 17'd1;
		return acc[15:8];
	endfunction

endpackage
`default_nettype wire

FILE: design/hsv2rgb_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Stages 1-2: hue wrap and sextant split, then percent to byte scaling.
// ----------------------------------------------------------------------------
module hsv2rgb_scale (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_vld,
	input  wire hsv2rgb_pkg::hsv_req_t in_req,
	output logic                       up_hold,
	output logic                       out_vld,
	output hsv2rgb_pkg::split_t        out_req,
	input  wire logic                  down_hold
);

	logic       en_s1, en_s2;
	logic       vld_s1, vld_s2;
	logic [8:0] hue_w;
	logic [2:0] sext_c;
	logic [8:0] base_c;
	logic [6:0] sat_c, bri_c;

	logic       szero_s1;
	logic [2:0] sext_s1;
	logic [5:0] rem_s1;
	logic [6:0] sat_s1, bri_s1;

	logic [14:0] sat255, bri255;
	logic [29:0] sat_prod, bri_prod;
	logic [9:0]  rem17;

	hsv2rgb_pkg::split_t req_s2;

	assign en_s2   = !vld_s2 || !down_hold;
	assign en_s1   = !vld_s1 || en_s2;
	assign up_hold = !en_s1;

	// Stage 1 logic
	always_comb begin
		hue_w = (in_req.hue >= hsv2rgb_pkg::HUE_FULL) ?
			in_req.hue - hsv2rgb_pkg::HUE_FULL : in_req.hue;
		sat_c = (in_req.saturation > hsv2rgb_pkg::PCT_MAX) ?
			hsv2rgb_pkg::PCT_MAX : in_req.saturation;
		bri_c = (in_req.brightness > hsv2rgb_pkg::PCT_MAX) ?
			hsv2rgb_pkg::PCT_MAX : in_req.brightness;
		if (hue_w < hsv2rgb_pkg::SEXT_DEG) begin
			sext_c = hsv2rgb_pkg::SEXT_RY;
			base_c = 9'd0;
		end else if (hue_w < hsv2rgb_pkg::SEXT_DEG * 9'd2) begin
			sext_c = hsv2rgb_pkg::SEXT_YG;
			base_c = hsv2rgb_pkg::SEXT_DEG;
		end else if (hue_w < hsv2rgb_pkg::SEXT_DEG * 9'd3) begin
			sext_c = hsv2rgb_pkg::SEXT_GC;
			base_c = hsv2rgb_pkg::SEXT_DEG * 9'd2;
		end else if (hue_w < hsv2rgb_pkg::SEXT_DEG * 9'd4) begin
			sext_c = hsv2rgb_pkg::SEXT_CB;
			base_c = hsv2rgb_pkg::SEXT_DEG * 9'd3;
		end else if (hue_w < hsv2rgb_pkg::SEXT_DEG * 9'd5) begin
			sext_c = hsv2rgb_pkg::SEXT_BM;
			base_c = hsv2rgb_pkg::SEXT_DEG * 9'd4;
		end else begin
			sext_c = hsv2rgb_pkg::SEXT_MR;
			base_c = hsv2rgb_pkg::SEXT_DEG * 9'd5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			szero_s1 <= (in_req.saturation == 7'd0);
			sext_s1  <= sext_c;
			rem_s1   <= 6'(hue_w - base_c);
			sat_s1   <= sat_c;
			bri_s1   <= bri_c;
		end
	end

	// Stage 2 logic: pct*255/100 and rem*255/60 (= rem*17/4)
	always_comb begin
		sat255   = {sat_s1, 8'd0} - 15'(sat_s1);
		bri255   = {bri_s1, 8'd0} - 15'(bri_s1);
		sat_prod = 30'(sat255) * 30'(hsv2rgb_pkg::RECIP_PCT);
		bri_prod = 30'(bri255) * 30'(hsv2rgb_pkg::RECIP_PCT);
		rem17    = {rem_s1, 4'd0} + 10'(rem_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			req_s2.sat_zero <= szero_s1;
			req_s2.sextant  <= sext_s1;
			req_s2.sat_b    <= sat_prod[hsv2rgb_pkg::RECIP_SHIFT +: 8];
			req_s2.val_b    <= bri_prod[hsv2rgb_pkg::RECIP_SHIFT +: 8];
			req_s2.frac     <= rem17[9:2];
		end
	end

	assign out_vld = vld_s2;
	assign out_req = req_s2;

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (req_s2.frac <= 8'd250))
		else $error("fraction above 250");
	a_sext_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (sext_s1 <= hsv2rgb_pkg::SEXT_MR && rem_s1 < 6'd60))
		else $error("sextant split out of range");
	a_scale_max: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s2 && vld_s1 && sat_s1 == hsv2rgb_pkg::PCT_MAX) |=> (req_s2.sat_b == 8'd255))
		else $error("full saturation not scaled to 255");

endmodule
`default_nettype wire

FILE: design/hsv2rgb_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_blend
// Stages 3-4: p, s*f/255 and s*(255-f)/255, then q and t.
// ----------------------------------------------------------------------------
module hsv2rgb_blend (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_vld,
	input  wire hsv2rgb_pkg::split_t in_req,
	output logic                     up_hold,
	output logic                     out_vld,
	output hsv2rgb_pkg::mix_t        out_req,
	input  wire logic                down_hold
);

	logic en_s3, en_s4;
	logic vld_s3, vld_s4;

	logic       szero_s3;
	logic [2:0] sext_s3;
	logic [7:0] v_s3, p_s3, sf_s3, st_s3;

	hsv2rgb_pkg::mix_t req_s4;

	assign en_s4   = !vld_s4 || !down_hold;
	assign en_s3   = !vld_s3 || en_s4;
	assign up_hold = !en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				vld_s3 <= in_vld;
			end
			if (en_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	// 255-x of a byte is its complement
	always_ff @(posedge clk) begin
		if (en_s3) begin
			szero_s3 <= in_req.sat_zero;
			sext_s3  <= in_req.sextant;
			v_s3     <= in_req.val_b;
			p_s3     <= hsv2rgb_pkg::div255(16'(in_req.val_b) * {8'd0, ~in_req.sat_b});
			sf_s3    <= hsv2rgb_pkg::div255(16'(in_req.sat_b) * 16'(in_req.frac));
			st_s3    <= hsv2rgb_pkg::div255(16'(in_req.sat_b) * {8'd0, ~in_req.frac});
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			req_s4.sat_zero <= szero_s3;
			req_s4.sextant  <= sext_s3;
			req_s4.val_b    <= v_s3;
			req_s4.p        <= p_s3;
			req_s4.q        <= hsv2rgb_pkg::div255(16'(v_s3) * {8'd0, ~sf_s3});
			req_s4.t        <= hsv2rgb_pkg::div255(16'(v_s3) * {8'd0, ~st_s3});
		end
	end

	assign out_vld = vld_s4;
	assign out_req = req_s4;

	// p is the floor of the blend, v its ceiling
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (req_s4.p <= req_s4.q && req_s4.p <= req_s4.t &&
			req_s4.q <= req_s4.val_b && req_s4.t <= req_s4.val_b))
		else $error("p/q/t ordering broken");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && down_hold) |=> (vld_s4 && $stable(req_s4)))
		else $error("stage 4 changed while held");
	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		up_hold |-> (vld_s3 && vld_s4 && down_hold))
		else $error("hold raised with a free stage");

endmodule
`default_nettype wire

FILE: design/hsv2rgb_route.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_route
// Stage 5: sextant routing of v, p, q, t into the output register.
// ----------------------------------------------------------------------------
module hsv2rgb_route (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_vld,
	input  wire hsv2rgb_pkg::mix_t in_req,
	output logic                   up_hold,
	output logic                   out_vld,
	output hsv2rgb_pkg::rgb_req_t  out_req,
	input  wire logic              down_hold
);

	logic en_s5;
	logic vld_s5;
	hsv2rgb_pkg::rgb_req_t rgb_c, rgb_s5;

	assign en_s5   = !vld_s5 || !down_hold;
	assign up_hold = !en_s5;

	always_comb begin
		if (in_req.sat_zero) begin
			rgb_c = '{red: in_req.val_b, green: in_req.val_b, blue: in_req.val_b};
		end else begin
			unique case (in_req.sextant)
				hsv2rgb_pkg::SEXT_RY: rgb_c = '{red: in_req.val_b, green: in_req.t,
					blue: in_req.p};
				hsv2rgb_pkg::SEXT_YG: rgb_c = '{red: in_req.q, green: in_req.val_b,
					blue: in_req.p};
				hsv2rgb_pkg::SEXT_GC: rgb_c = '{red: in_req.p, green: in_req.val_b,
					blue: in_req.t};
				hsv2rgb_pkg::SEXT_CB: rgb_c = '{red: in_req.p, green: in_req.q,
					blue: in_req.val_b};
				hsv2rgb_pkg::SEXT_BM: rgb_c = '{red: in_req.t, green: in_req.p,
					blue: in_req.val_b};
				default:              rgb_c = '{red: in_req.val_b, green: in_req.p,
					blue: in_req.q};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en_s5) begin
			vld_s5 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			rgb_s5 <= rgb_c;
		end
	end

	assign out_vld = vld_s5;
	assign out_req = rgb_s5;

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s5 && in_vld && in_req.sat_zero) |=>
		(rgb_s5.red == rgb_s5.green && rgb_s5.green == rgb_s5.blue))
		else $error("grey request gave unequal channels");
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s5 && in_vld) |=> (rgb_s5.red == $past(in_req.val_b) ||
			rgb_s5.green == $past(in_req.val_b) || rgb_s5.blue == $past(in_req.val_b)))
		else $error("no channel carries v");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s5 && in_vld) |=> vld_s5)
		else $error("request lost at output stage");

endmodule
`default_nettype wire

FILE: design/hsv_to_rgb_converter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// Integer HSV (degrees, percent) to 8-bit RGB converter, five-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  hsv     | in  | hsv_valid/hsv_stall  | hue 9b, saturation 7b, brightness 7b
//  rgb     | out | rgb_valid/rgb_stall  | red 8b, green 8b, blue 8b
//
//  One request per clock is taken when rgb is not stalled.
//  Stages: hue wrap/sextant split, percent scaling (two reciprocal
//  multipliers), p, s*f and s*(255-f) products, q and t products, routing register.
//  Each stage has its own valid bit and loads whenever it is empty or the
//  stage after it moves, so bubbles close up under a stall.
//  hsv_stall rises only once all five stages are full and rgb is stalled.
//  arst_n clears the valid bits only; data registers are not reset.
//
module hsv_to_rgb_converter_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  hsv_valid,
	output logic                       hsv_stall,
	input  wire hsv2rgb_pkg::hsv_req_t hsv,
	output logic                       rgb_valid,
	input  wire logic                  rgb_stall,
	output hsv2rgb_pkg::rgb_req_t      rgb
);

	logic                vld_split, hold_split;
	logic                vld_mix, hold_mix;
	hsv2rgb_pkg::split_t req_split;
	hsv2rgb_pkg::mix_t   req_mix;

	// Stages 1-2
	hsv2rgb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (hsv_valid),
		.in_req    (hsv),
		.up_hold   (hsv_stall),
		.out_vld   (vld_split),
		.out_req   (req_split),
		.down_hold (hold_split)
	);

	// Stages 3-4
	hsv2rgb_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld_split),
		.in_req    (req_split),
		.up_hold   (hold_split),
		.out_vld   (vld_mix),
		.out_req   (req_mix),
		.down_hold (hold_mix)
	);

	// Stage 5, output register
	hsv2rgb_route u_route (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld_mix),
		.in_req    (req_mix),
		.up_hold   (hold_mix),
		.out_vld   (rgb_valid),
		.out_req   (rgb),
		.down_hold (rgb_stall)
	);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_stall |-> (rgb_valid && rgb_stall))
		else $error("input stalled while output free");
	a_chain_full: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_stall |-> (vld_split && vld_mix && hold_split && hold_mix))
		else $error("input stalled with a bubble in the pipe");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!rgb_stall && !vld_mix) |=> !rgb_valid)
		else $error("output request repeated");

endmodule
`default_nettype wire

FILE: dv/hsv_to_rgb_converter_top_test.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top_test
// Self-checking bench for the HSV to RGB converter. Colour requests are
// pushed in with random gaps while the output side stalls in random bursts.
// A scoreboard works out the expected 8-bit channels and compares every
// result in order, field by field.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top_test;
	import hsv2rgb_pkg::*;

	localparam int unsigned FULL_SCALE = 255;
	localparam int          RUN_ITEMS  = 1250;
	localparam int          PHASE_LEN  = 125;

	// Scoreboard: one expected colour per accepted request, kept in order
	class rgb_scoreboard;
		typedef struct {
			hsv_req_t req;
			rgb_req_t want;
		} pending_t;

		pending_t waiting_q[$];
		int       errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return waiting_q.size();
		endfunction

		// Integer conversion: percent scaled to a byte, hue split by sextant
		function rgb_req_t predict_rgb(hsv_req_t c);
			int unsigned h, sp, vp, s, v, f, p, q, t;
			logic [2:0]  sext;
			rgb_req_t    o;
			h = c.hue;
			if (h >= HUE_FULL)
				h = h - HUE_FULL;
			sp = (c.saturation > PCT_MAX) ? PCT_MAX : c.saturation;
			vp = (c.brightness > PCT_MAX) ? PCT_MAX : c.brightness;
			s  = sp * FULL_SCALE / PCT_MAX;
			v  = vp * FULL_SCALE / PCT_MAX;
			// grey: the raw saturation decides, not the scaled one
			if (c.saturation == 0) begin
				o = {8'(v), 8'(v), 8'(v)};
				return o;
			end
			sext = 3'(h / SEXT_DEG);
			f = (h % SEXT_DEG) * FULL_SCALE / SEXT_DEG;
			p = v * (FULL_SCALE - s) / FULL_SCALE;
			q = v * (FULL_SCALE - s * f / FULL_SCALE) / FULL_SCALE;
			t = v * (FULL_SCALE - s * (FULL_SCALE - f) / FULL_SCALE) / FULL_SCALE;
			case (sext)
				SEXT_RY: o = {8'(v), 8'(t), 8'(p)};
				SEXT_YG: o = {8'(q), 8'(v), 8'(p)};
				SEXT_GC: o = {8'(p), 8'(v), 8'(t)};
				SEXT_CB: o = {8'(p), 8'(q), 8'(v)};
				SEXT_BM: o = {8'(t), 8'(p), 8'(v)};
				default: o = {8'(v), 8'(p), 8'(q)};
			endcase
			return o;
		endfunction

		function void note_request(hsv_req_t c);
			pending_t e;
			e.req  = c;
			e.want = predict_rgb(c);
			waiting_q.push_back(e);
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(rgb_req_t got);
			pending_t e;
			string    tag;
			if (waiting_q.size() == 0) begin
				report($sformatf("unexpected result r=%0d g=%0d b=%0d",
					got.red, got.green, got.blue));
				return;
			end
			e = waiting_q.pop_front();
			tag = $sformatf("h=%0d s=%0d v=%0d", e.req.hue, e.req.saturation,
				e.req.brightness);
			if (got.red !== e.want.red)
				report($sformatf("%s red %0d want %0d", tag, got.red, e.want.red));
			if (got.green !== e.want.green)
				report($sformatf("%s green %0d want %0d", tag, got.green, e.want.green));
			if (got.blue !== e.want.blue)
				report($sformatf("%s blue %0d want %0d", tag, got.blue, e.want.blue));
		endtask
	endclass

	// DUT connections; every input known from time zero
	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     hsv_valid = 1'b0;
	logic     hsv_stall;
	hsv_req_t hsv       = '0;
	logic     rgb_valid;
	logic     rgb_stall = 1'b0;
	rgb_req_t rgb;

	// Idle pressure, in percent per request / per cycle; zero means none
	int gap_pct   = 0;
	int stall_pct = 0;

	rgb_scoreboard book = new();

	hsv_to_rgb_converter_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_stall (hsv_stall),
		.hsv       (hsv),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall),
		.rgb       (rgb)
	);

	always #2 clk = ~clk;

	// Output side: random stall bursts, chance set per phase
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				rgb_stall <= 1'b1;
				hold--;
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				rgb_stall <= 1'b1;
				hold = $urandom_range(18);
			end else begin
				rgb_stall <= 1'b0;
			end
		end
	end

	// Result monitor; values seen here are the ones before this edge's updates
	always @(posedge clk) begin
		if (arst_n && rgb_valid && !rgb_stall)
			book.check_result(rgb);
	end

	// One request: optional gap with valid low, then hold until taken.
	// Called at a rising edge; returns at the edge that accepted it.
	task automatic send_hsv(input hsv_req_t item);
		int gap;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			gap = $urandom_range(19, 1);
			hsv_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hsv       <= item;
		hsv_valid <= 1'b1;
		@(posedge clk);
		while (hsv_stall)
			@(posedge clk);
		book.note_request(item);
	endtask

	function automatic hsv_req_t make_hsv(int h, int s, int v);
		hsv_req_t c;
		c.hue        = 9'(h);
		c.saturation = 7'(s);
		c.brightness = 7'(v);
		return c;
	endfunction

	// Mostly legal colours; some grey, some on sextant edges, some with
	// wrapped hue or over-range percent
	function automatic hsv_req_t random_hsv();
		hsv_req_t c;
		int       pick;
		pick = $urandom_range(99);
		c = make_hsv($urandom_range(359), $urandom_range(100), $urandom_range(100));
		if (pick < 8)
			c.saturation = '0;
		else if (pick < 16)
			c.hue = 9'(60 * $urandom_range(5) + $urandom_range(1) * 59);
		else if (pick < 22)
			c.saturation = 7'($urandom_range(100) == 0 ? 100 : $urandom_range(127, 90));
		else if (pick < 34)
			c = make_hsv($urandom_range(511), $urandom_range(127), $urandom_range(127));
		return c;
	endfunction

	// Directed colours: corners, each sextant, grey, wrapped hue, clipping
	hsv_req_t directed_q[$] = '{
		'{9'd0,   7'd0,   7'd0},
		'{9'd0,   7'd0,   7'd100},
		'{9'd150, 7'd0,   7'd63},
		'{9'd0,   7'd100, 7'd100},
		'{9'd59,  7'd100, 7'd100},
		'{9'd60,  7'd100, 7'd100},
		'{9'd120, 7'd100, 7'd100},
		'{9'd180, 7'd100, 7'd100},
		'{9'd240, 7'd100, 7'd100},
		'{9'd300, 7'd100, 7'd100},
		'{9'd359, 7'd100, 7'd100},
		'{9'd30,  7'd50,  7'd75},
		'{9'd90,  7'd100, 7'd0},
		'{9'd255, 7'd85,  7'd42},
		'{9'd360, 7'd100, 7'd100},
		'{9'd400, 7'd127, 7'd50},
		'{9'd511, 7'd127, 7'd127},
		'{9'd200, 7'd101, 7'd100},
		'{9'd0,   7'd64,  7'd127},
		'{9'd300, 7'd127, 7'd0},
		'{9'd1,   7'd1,   7'd1}
	};

	initial begin
		int phase;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under light pressure
		gap_pct   = 20;
		stall_pct = 10;
		foreach (directed_q[i])
			send_hsv(directed_q[i]);

		// random part; pressure changes each phase, last two phases are calm
		for (int n = 0; n < RUN_ITEMS; n++) begin
			if (n % PHASE_LEN == 0) begin
				phase = n / PHASE_LEN;
				if (phase >= RUN_ITEMS / PHASE_LEN - 2) begin
					gap_pct   = 0;
					stall_pct = 0;
				end else begin
					case ($urandom_range(3))
						0: gap_pct = 0;
						1: gap_pct = 5;
						2: gap_pct = 25;
						default: gap_pct = 60;
					endcase
					case ($urandom_range(3))
						0: stall_pct = 0;
						1: stall_pct = 3;
						2: stall_pct = 15;
						default: stall_pct = 40;
					endcase
				end
			end
			send_hsv(random_hsv());
		end
		hsv_valid <= 1'b0;

		// drain, then keep watching to catch stray results
		while (book.pending() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		if (book.errors == 0 && book.pending() == 0) begin
			$display("hsv_to_rgb_converter_top regression: pass");
		end else begin
			$display("hsv_to_rgb_converter_top regression: fail");
		end
		$finish;
	end

	// Watchdog: well beyond the slowest legal run
	initial begin
		#2000000;
		$display("hsv_to_rgb_converter_top regression: fail");
		$finish;
	end

endmodule
